// ----- rtl/imu_frame_parser_macros.svh -----
// assertion macros shared by the frame parser modules
`ifndef IMU_FRAME_PARSER_MACROS_SVH
`define IMU_FRAME_PARSER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, held off during reset
`define IMFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("imu frame parser: assertion failed");

// next-cycle implication, held off during reset
`define IMFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("imu frame parser: assertion failed");

`else

`define IMFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IMFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/imfp_pkg.sv -----
// types and constants shared by the frame parser modules
package imfp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'h31;

  // byte position codes
  localparam logic [4:0] POS_HUNT       = 5'd0;
  localparam logic [4:0] POS_WORD_FIRST = 5'd1;
  localparam logic [4:0] POS_WORD_LAST  = 5'd20;
  localparam logic [4:0] POS_CSUM_HI    = 5'd21;
  localparam logic [4:0] POS_CSUM_LO    = 5'd22;

  // kept word slots
  localparam int unsigned NUM_SLOTS = 7;
  localparam logic [2:0] SLOT_ROLL       = 3'd0;
  localparam logic [2:0] SLOT_PITCH      = 3'd1;
  localparam logic [2:0] SLOT_YAW        = 3'd2;
  localparam logic [2:0] SLOT_ROLL_RATE  = 3'd3;
  localparam logic [2:0] SLOT_PITCH_RATE = 3'd4;
  localparam logic [2:0] SLOT_YAW_RATE   = 3'd5;
  localparam logic [2:0] SLOT_TICK       = 3'd6;

  // word indexes that bound the kept groups
  localparam logic [3:0] WIDX_ATT_LAST  = 4'd2;
  localparam logic [3:0] WIDX_RATE_BASE = 4'd6;
  localparam logic [3:0] WIDX_SKIPPED   = 4'd3;

  // one registered input byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } beat_t;

  // one frame result
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic        [15:0] tick_stamp;
    logic               checksum_ok;
  } frame_t;

endpackage

// ----- rtl/imfp_in_reg.sv -----
// input register for received bytes
`include "imu_frame_parser_macros.svh"

module imfp_in_reg
  import imfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output beat_t      beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       accept;

  // hold off the sender only while a beat waits on the parser
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // byte payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= rx_byte_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;

  `IMFP_ASSERT_IMP(a_adv_needs_beat, clk_i, rst_ni, advance_i, valid_q)
  `IMFP_ASSERT_NXT(a_accept_loads, clk_i, rst_ni, accept, valid_q && data_q == $past(rx_byte_i))
  `IMFP_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, in_stall_o, valid_q && $stable(data_q))

endmodule

// ----- rtl/imfp_core.sv -----
// frame position tracking, word capture, checksum and result register
`include "imu_frame_parser_macros.svh"

module imfp_core
  import imfp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  beat_t  beat_i,
  output logic   advance_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output frame_t frame_o
);

  logic [4:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  hi_q, hi_d;
  logic [7:0]  csum_hi_q, csum_hi_d;
  logic [15:0] words_q [NUM_SLOTS];
  logic [15:0] words_d [NUM_SLOTS];
  logic        out_valid_q, out_valid_d;
  frame_t      frame_q;

  logic        emit;
  logic        slot_free;
  logic        emit_fire;
  logic [15:0] word;
  logic [15:0] rx_sum;
  logic [3:0]  widx;
  logic        keep;
  logic [2:0]  slot;

  // word index to store slot; middle words are dropped
  always_comb begin
    widx = pos_q[4:1] - 4'd1;
    keep = 1'b0;
    slot = SLOT_ROLL;
    if (widx <= WIDX_ATT_LAST) begin
      keep = 1'b1;
      slot = widx[2:0];
    end else if (widx >= WIDX_RATE_BASE) begin
      keep = 1'b1;
      slot = 3'(widx - WIDX_SKIPPED);
    end
  end

  assign word   = {hi_q, beat_i.data};
  assign rx_sum = {csum_hi_q, beat_i.data};

  // next state for one byte
  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    hi_d      = hi_q;
    csum_hi_d = csum_hi_q;
    words_d   = words_q;
    emit      = 1'b0;
    case (pos_q)
      POS_HUNT: begin
        if (beat_i.data == HDR_BYTE) begin
          sum_d = {8'h00, HDR_BYTE};
          pos_d = POS_WORD_FIRST;
        end
      end
      POS_CSUM_HI: begin
        csum_hi_d = beat_i.data;
        pos_d     = POS_CSUM_LO;
      end
      POS_CSUM_LO: begin
        emit  = 1'b1;
        pos_d = POS_HUNT;
      end
      default: begin
        if (pos_q inside {[POS_WORD_FIRST:POS_WORD_LAST]}) begin
          if (pos_q[0]) begin
            hi_d = beat_i.data;
          end else begin
            sum_d = sum_q + word;
            if (keep) begin
              words_d[slot] = word;
            end
          end
          pos_d = pos_q + 5'd1;
        end else begin
          pos_d = POS_HUNT;
        end
      end
    endcase
  end

  // a byte that ends a frame waits for a free result slot
  assign slot_free = !out_valid_q || !out_stall_i;
  assign advance_o = beat_i.valid && (!emit || slot_free);
  assign emit_fire = advance_o && emit;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_HUNT;
      sum_q       <= '0;
      hi_q        <= '0;
      csum_hi_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        words_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        pos_q     <= pos_d;
        sum_q     <= sum_d;
        hi_q      <= hi_d;
        csum_hi_q <= csum_hi_d;
        words_q   <= words_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      frame_q.roll        <= words_q[SLOT_ROLL];
      frame_q.pitch       <= words_q[SLOT_PITCH];
      frame_q.yaw         <= words_q[SLOT_YAW];
      frame_q.roll_rate   <= words_q[SLOT_ROLL_RATE];
      frame_q.pitch_rate  <= words_q[SLOT_PITCH_RATE];
      frame_q.yaw_rate    <= words_q[SLOT_YAW_RATE];
      frame_q.tick_stamp  <= words_q[SLOT_TICK];
      frame_q.checksum_ok <= (rx_sum == sum_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_o     = frame_q;

  `IMFP_ASSERT_IMP(a_pos_range, clk_i, rst_ni, 1'b1, pos_q <= POS_CSUM_LO)
  `IMFP_ASSERT_NXT(a_emit_rehunt, clk_i, rst_ni, emit_fire, out_valid_q && pos_q == POS_HUNT)
  `IMFP_ASSERT_NXT(a_hunt_skip, clk_i, rst_ni,
                   advance_o && pos_q == POS_HUNT && beat_i.data != HDR_BYTE,
                   pos_q == POS_HUNT)

endmodule

// ----- rtl/imu_frame_parser.sv -----
// top level of the inertial sensor frame parser
//
// Input channel: one received byte per beat on rx_byte_i, handshake
// in_valid_i / in_stall_o. Output channel: one frame result per beat on
// the roll_o .. checksum_ok_o ports, handshake out_valid_o / out_stall_i.
// A beat moves at a clock edge where valid is high and stall is low.
// The parser hunts for header byte 0x31, then takes ten big-endian words
// (three attitude, three dropped acceleration, three rates, one tick)
// and a big-endian checksum. A frame is delivered on every checksum low
// byte; checksum_ok_o tells whether header plus words matched it.
// Throughput: one byte per cycle while no frame-closing byte waits on
// a full, stalled result register, set by the combinational position and
// word-sum update between the input register and the result register.
// The result register loads from the checksum byte in the input register.
// Reset clears the position to hunting, the sums and the stored words.
// While the result register is full and stalled, the byte that closes
// the next frame waits in the input register and in_stall_o rises; all
// other bytes keep flowing.
module imu_frame_parser
  import imfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [7:0]  rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_o,
  output logic signed [15:0] pitch_o,
  output logic signed [15:0] yaw_o,
  output logic signed [15:0] roll_rate_o,
  output logic signed [15:0] pitch_rate_o,
  output logic signed [15:0] yaw_rate_o,
  output logic        [15:0] tick_stamp_o,
  output logic               checksum_ok_o
);

  beat_t  beat;
  logic   advance;
  frame_t frame;

  // input byte register
  imfp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .beat_o     (beat)
  );

  // parser and result register
  imfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_o     (frame)
  );

  assign roll_o        = frame.roll;
  assign pitch_o       = frame.pitch;
  assign yaw_o         = frame.yaw;
  assign roll_rate_o   = frame.roll_rate;
  assign pitch_rate_o  = frame.pitch_rate;
  assign yaw_rate_o    = frame.yaw_rate;
  assign tick_stamp_o  = frame.tick_stamp;
  assign checksum_ok_o = frame.checksum_ok;

endmodule
